FILE: src/rrts_pkg.sv
// Shared types and constants for the round-robin task scheduler.
package rrts_pkg;

   localparam int ACTION_W   = 4;
   localparam int DUR_W      = 32;
   localparam int TICK_W     = 64;
   localparam int PORT_ID_W  = 6;
   localparam int SLOT_W     = 10;
   localparam int DIVIDEND_W = DUR_W + 1;

   localparam logic [ACTION_W-1:0] ACT_TICK        = 4'd0;
   localparam logic [ACTION_W-1:0] ACT_YIELD       = 4'd1;
   localparam logic [ACTION_W-1:0] ACT_BLOCK       = 4'd2;
   localparam logic [ACTION_W-1:0] ACT_SLEEP_MS    = 4'd3;
   localparam logic [ACTION_W-1:0] ACT_SLEEP_UNTIL = 4'd4;
   localparam logic [ACTION_W-1:0] ACT_WAKE        = 4'd5;
   localparam logic [ACTION_W-1:0] ACT_EXIT        = 4'd6;
   localparam logic [ACTION_W-1:0] ACT_CREATE      = 4'd7;
   localparam logic [ACTION_W-1:0] ACT_COLLECT     = 4'd8;

   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_NO_FREE_ID = 2'd1;
   localparam logic [1:0] STATUS_NOT_BLOCKED = 2'd2;
   localparam logic [1:0] STATUS_EXIT_QUEUE = 2'd3;

   localparam logic [SLOT_W-1:0] SLOT_RESET = 10'd10;

   // Commands from the sequencer to the ready queue.
   typedef struct packed {
      logic rd;    // read the head entry, data valid next cycle
      logic pop;   // advance the head
      logic push;  // append at the tail
   } rq_cmd_type;

endpackage

FILE: src/round_robin_task_scheduler.sv
// Top level of the round-robin task scheduler with sleep timers.
//
// The req channel carries one scheduler event per word: an action code and
// its operands. The rsp channel returns one word per event with the task
// that runs afterwards, a switched flag, a status code and the id created or
// freed. The csr port writes slot_time_ms, the tick length used to round
// sleep durations up to whole ticks; a value of zero counts as one.
//
// Events are handled one at a time by a sequencer around three memories:
// the ready queue, the per-task wake-up ticks and the exit queue. Per-task
// flags (blocked, sleeping, allocated) live in flip-flops.
// Sleep_ms runs a 33-step divider, tick issues one wake-tick read per task,
// and create probes the ids in turn until it finds a free one.
// A new word is accepted once the previous one reaches the response register;
// a stalled receiver holds back at most one more event.
// Reset is synchronous; it restores task 0 running, task 1 queued, the idle
// task ready, the tick counter at zero and slot_time_ms at 10, and needs no
// clearing pass.
module round_robin_task_scheduler #(
   parameter int MAX_TASKS  = 64,
   parameter int EXIT_DEPTH = 16,
   parameter int IDLE_ID    = 2
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [rrts_pkg::SLOT_W-1:0]       csr_wr_data,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [rrts_pkg::ACTION_W-1:0]     req_action,
   input  logic [rrts_pkg::DUR_W-1:0]        req_duration_ms,
   input  logic [rrts_pkg::TICK_W-1:0]       req_wake_at_tick,
   input  logic [rrts_pkg::PORT_ID_W-1:0]    req_target_task,
   input  logic                              req_from_interrupt,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [rrts_pkg::PORT_ID_W-1:0]    rsp_running_task,
   output logic                              rsp_switched,
   output logic [1:0]                        rsp_status,
   output logic [rrts_pkg::PORT_ID_W-1:0]    rsp_affected_task
);

   localparam int IdW     = $clog2(MAX_TASKS);
   localparam int CntW    = $clog2(MAX_TASKS + 1);
   localparam int ExW     = $clog2(EXIT_DEPTH);
   localparam int ExCntW  = $clog2(EXIT_DEPTH + 1);
   localparam int ExSumW  = ExW + 2;
   localparam int WideW   = 9;
   localparam int IdleId  = IDLE_ID % MAX_TASKS;
   localparam int TW      = rrts_pkg::TICK_W;
   localparam int PW      = rrts_pkg::PORT_ID_W;

   typedef enum logic [8:0] {
      S_IDLE   = 9'b000000001,
      S_EXEC   = 9'b000000010,
      S_DIV    = 9'b000000100,
      S_SCAN   = 9'b000001000,
      S_ROT_RD = 9'b000010000,
      S_ROT_WR = 9'b000100000,
      S_SRCH   = 9'b001000000,
      S_COL_WR = 9'b010000000,
      S_DONE   = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   // Latched request word.
   logic [rrts_pkg::ACTION_W-1:0]  act_ff;
   logic [rrts_pkg::DUR_W-1:0]     dur_ff;
   logic [TW-1:0]                  until_ff;
   logic [PW-1:0]                  tgt_ff;
   logic                           fromint_ff;

   logic [rrts_pkg::SLOT_W-1:0]    slot_ff, slot_in;
   logic [IdW-1:0]                 cur_ff, cur_in;
   logic [IdW-1:0]                 before_ff;
   logic [TW-1:0]                  tick_ff, tick_in;
   logic [MAX_TASKS-1:0]           blocked_ff, blocked_in;
   logic [MAX_TASKS-1:0]           sleeping_ff, sleeping_in;
   logic [MAX_TASKS-1:0]           used_ff, used_in;
   logic [IdW-1:0]                 search_ff, search_in;
   logic                           requeue_ff, requeue_in;
   logic [CntW-1:0]                scan_ff, scan_in;
   logic                           chk_valid_ff, chk_valid_in;
   logic [IdW-1:0]                 chk_idx_ff;
   logic [IdW-1:0]                 probe_ff, probe_in;
   logic [CntW-1:0]                probe_cnt_ff, probe_cnt_in;
   logic [1:0]                     status_ff, status_in;
   logic [IdW-1:0]                 affected_ff, affected_in;

   logic [ExW-1:0]                 ex_head_ff, ex_head_in;
   logic [ExCntW-1:0]              ex_count_ff, ex_count_in;
   logic [ExSumW-1:0]              ex_sum;
   logic [ExW-1:0]                 ex_tail;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [PW-1:0]                  rsp_run_ff;
   logic                           rsp_sw_ff;
   logic [1:0]                     rsp_status_ff;
   logic [PW-1:0]                  rsp_aff_ff;
   logic                           rsp_load;

   // Wake-tick and exit-queue memories.
   logic [TW-1:0]                  wake_mem [MAX_TASKS];
   logic [TW-1:0]                  wake_q_ff;
   logic                           wk_we, wk_re;
   logic [IdW-1:0]                 wk_waddr;
   logic [TW-1:0]                  wk_wdata;
   logic [IdW-1:0]                 ex_mem [EXIT_DEPTH];
   logic [IdW-1:0]                 ex_q_ff;
   logic                           ex_we, ex_re;

   rrts_pkg::rq_cmd_type           rq_cmd;
   logic [IdW-1:0]                 rq_push_id;
   logic [CntW-1:0]                rq_count;
   logic [IdW-1:0]                 rq_data;

   logic                           div_start, div_done;
   logic [rrts_pkg::DIVIDEND_W-1:0] div_q;
   logic [rrts_pkg::SLOT_W-1:0]    slot_eff;
   logic [rrts_pkg::DIVIDEND_W-1:0] dividend;

   logic                           accept;
   logic [IdW-1:0]                 tgt_idx;
   logic                           tgt_ok;
   logic [WideW-1:0]               cur_wide, aff_wide;
   logic [IdW-1:0]                 coll_idx;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign slot_eff  = (slot_ff == '0) ? rrts_pkg::SLOT_W'(1) : slot_ff;
   assign dividend  = rrts_pkg::DIVIDEND_W'(dur_ff) + rrts_pkg::DIVIDEND_W'(slot_eff)
                      - rrts_pkg::DIVIDEND_W'(1);
   assign tgt_idx   = IdW'(tgt_ff);
   assign tgt_ok    = (WideW'(tgt_ff) < WideW'(MAX_TASKS)) && blocked_ff[tgt_idx];
   assign coll_idx  = IdW'(1);
   assign ex_sum    = ExSumW'(ex_head_ff) + ExSumW'(ex_count_ff);
   assign ex_tail   = (ex_sum >= ExSumW'(EXIT_DEPTH)) ? ExW'(ex_sum - ExSumW'(EXIT_DEPTH))
                                                      : ExW'(ex_sum);
   assign rsp_load  = !rsp_valid_ff || rsp_ready;
   assign cur_wide  = WideW'(cur_ff);
   assign aff_wide  = WideW'(affected_ff);

   rrts_ready_queue #(.MAX_TASKS(MAX_TASKS)) u_ready_queue (
      .clock   (clock),
      .reset   (reset),
      .cmd     (rq_cmd),
      .push_id (rq_push_id),
      .count   (rq_count),
      .rd_data (rq_data)
   );

   rrts_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (slot_eff),
      .done     (div_done),
      .quotient (div_q)
   );

   always_comb begin
      state_in     = state_ff;
      slot_in      = csr_wr_en ? csr_wr_data : slot_ff;
      cur_in       = cur_ff;
      tick_in      = tick_ff;
      blocked_in   = blocked_ff;
      sleeping_in  = sleeping_ff;
      used_in      = used_ff;
      search_in    = search_ff;
      requeue_in   = requeue_ff;
      scan_in      = scan_ff;
      chk_valid_in = 1'b0;
      probe_in     = probe_ff;
      probe_cnt_in = probe_cnt_ff;
      status_in    = status_ff;
      affected_in  = affected_ff;
      ex_head_in   = ex_head_ff;
      ex_count_in  = ex_count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rq_cmd       = '0;
      rq_push_id   = cur_ff;
      wk_we        = 1'b0;
      wk_re        = 1'b0;
      wk_waddr     = cur_ff;
      wk_wdata     = until_ff;
      ex_we        = 1'b0;
      ex_re        = 1'b0;
      div_start    = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
            end
         end

         S_EXEC: begin
            status_in   = rrts_pkg::STATUS_OK;
            affected_in = '0;
            state_in    = S_DONE;
            unique case (act_ff)
               rrts_pkg::ACT_TICK: begin
                  tick_in  = tick_ff + TW'(1);
                  scan_in  = '0;
                  state_in = S_SCAN;
               end
               rrts_pkg::ACT_YIELD: begin
                  requeue_in = 1'b1;
                  state_in   = S_ROT_RD;
               end
               rrts_pkg::ACT_BLOCK: begin
                  blocked_in[cur_ff] = 1'b1;
                  requeue_in         = 1'b0;
                  state_in           = S_ROT_RD;
               end
               rrts_pkg::ACT_SLEEP_MS: begin
                  div_start = 1'b1;
                  state_in  = S_DIV;
               end
               rrts_pkg::ACT_SLEEP_UNTIL: begin
                  wk_we               = 1'b1;
                  sleeping_in[cur_ff] = 1'b1;
                  blocked_in[cur_ff]  = 1'b1;
                  requeue_in          = 1'b0;
                  state_in            = S_ROT_RD;
               end
               rrts_pkg::ACT_WAKE: begin
                  if (!tgt_ok) begin
                     status_in = rrts_pkg::STATUS_NOT_BLOCKED;
                  end else begin
                     sleeping_in[tgt_idx] = 1'b0;
                     blocked_in[tgt_idx]  = 1'b0;
                     rq_cmd.push          = 1'b1;
                     rq_push_id           = tgt_idx;
                     // An interrupt wake-up preempts the idle task at once.
                     if (fromint_ff && (cur_ff == IdW'(IdleId))) begin
                        requeue_in = 1'b1;
                        state_in   = S_ROT_RD;
                     end
                  end
               end
               rrts_pkg::ACT_EXIT: begin
                  if (ex_count_ff >= ExCntW'(EXIT_DEPTH)) begin
                     status_in = rrts_pkg::STATUS_EXIT_QUEUE;
                  end else begin
                     ex_we       = 1'b1;
                     ex_count_in = ex_count_ff + ExCntW'(1);
                     // Every accepted exit wakes the collector if it is blocked.
                     if (blocked_ff[coll_idx]) begin
                        sleeping_in[coll_idx] = 1'b0;
                        blocked_in[coll_idx]  = 1'b0;
                        rq_cmd.push           = 1'b1;
                        rq_push_id            = coll_idx;
                     end
                     blocked_in[cur_ff] = 1'b0;
                     requeue_in         = 1'b0;
                     state_in           = S_ROT_RD;
                  end
               end
               rrts_pkg::ACT_CREATE: begin
                  probe_in     = search_ff;
                  probe_cnt_in = '0;
                  state_in     = S_SRCH;
               end
               rrts_pkg::ACT_COLLECT: begin
                  if (ex_count_ff == '0) begin
                     status_in = rrts_pkg::STATUS_EXIT_QUEUE;
                  end else begin
                     ex_re    = 1'b1;
                     state_in = S_COL_WR;
                  end
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end

         S_DIV: begin
            if (div_done) begin
               wk_we               = 1'b1;
               wk_wdata            = tick_ff + TW'(div_q);
               sleeping_in[cur_ff] = 1'b1;
               blocked_in[cur_ff]  = 1'b1;
               requeue_in          = 1'b0;
               state_in            = S_ROT_RD;
            end
         end

         S_SCAN: begin
            // Read stage issues one wake-tick read per cycle; the check stage
            // wakes the expired sleeper in the next cycle, in id order.
            if (scan_ff != CntW'(MAX_TASKS)) begin
               wk_re        = 1'b1;
               chk_valid_in = 1'b1;
               scan_in      = scan_ff + CntW'(1);
            end else if (!chk_valid_ff) begin
               requeue_in = 1'b1;
               state_in   = S_ROT_RD;
            end
            if (chk_valid_ff && sleeping_ff[chk_idx_ff] && (tick_ff >= wake_q_ff)
                && blocked_ff[chk_idx_ff]) begin
               sleeping_in[chk_idx_ff] = 1'b0;
               blocked_in[chk_idx_ff]  = 1'b0;
               rq_cmd.push             = 1'b1;
               rq_push_id              = chk_idx_ff;
            end
         end

         S_ROT_RD: begin
            if (rq_count == '0) begin
               // A rotation with nothing queued changes nothing; a switch
               // away falls back to the idle task.
               if (!requeue_ff) begin
                  cur_in                       = IdW'(IdleId);
                  blocked_in[IdW'(IdleId)]     = 1'b0;
               end
               state_in = S_DONE;
            end else begin
               rq_cmd.rd = 1'b1;
               state_in  = S_ROT_WR;
            end
         end

         S_ROT_WR: begin
            rq_cmd.pop = 1'b1;
            if (requeue_ff && (cur_ff != IdW'(IdleId))) begin
               blocked_in[cur_ff] = 1'b0;
               rq_cmd.push        = 1'b1;
               rq_push_id         = cur_ff;
            end
            blocked_in[rq_data] = 1'b0;
            cur_in              = rq_data;
            state_in            = S_DONE;
         end

         S_SRCH: begin
            if (!used_ff[probe_ff]) begin
               used_in[probe_ff]     = 1'b1;
               sleeping_in[probe_ff] = 1'b0;
               blocked_in[probe_ff]  = 1'b0;
               rq_cmd.push           = 1'b1;
               rq_push_id            = probe_ff;
               search_in   = (probe_ff == IdW'(MAX_TASKS - 1)) ? '0 : probe_ff + IdW'(1);
               affected_in = probe_ff;
               state_in    = S_DONE;
            end else if (probe_cnt_ff == CntW'(MAX_TASKS - 1)) begin
               status_in = rrts_pkg::STATUS_NO_FREE_ID;
               state_in  = S_DONE;
            end else begin
               probe_in     = (probe_ff == IdW'(MAX_TASKS - 1)) ? '0 : probe_ff + IdW'(1);
               probe_cnt_in = probe_cnt_ff + CntW'(1);
            end
         end

         S_COL_WR: begin
            used_in[ex_q_ff]    = 1'b0;
            blocked_in[ex_q_ff] = 1'b0;
            affected_in         = ex_q_ff;
            ex_head_in  = (ex_head_ff == ExW'(EXIT_DEPTH - 1)) ? '0 : ex_head_ff + ExW'(1);
            ex_count_in = ex_count_ff - ExCntW'(1);
            state_in    = S_DONE;
         end

         S_DONE: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         slot_ff       <= rrts_pkg::SLOT_RESET;
         cur_ff        <= '0;
         tick_ff       <= '0;
         blocked_ff    <= '0;
         sleeping_ff   <= '0;
         // Task 0, the collector and the idle task start allocated.
         used_ff       <= MAX_TASKS'(1) | (MAX_TASKS'(1) << 1) | (MAX_TASKS'(1) << IdleId);
         search_ff     <= IdW'(3 % MAX_TASKS);
         ex_head_ff    <= '0;
         ex_count_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
         chk_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         slot_ff       <= slot_in;
         cur_ff        <= cur_in;
         tick_ff       <= tick_in;
         blocked_ff    <= blocked_in;
         sleeping_ff   <= sleeping_in;
         used_ff       <= used_in;
         search_ff     <= search_in;
         ex_head_ff    <= ex_head_in;
         ex_count_ff   <= ex_count_in;
         rsp_valid_ff  <= rsp_valid_in;
         chk_valid_ff  <= chk_valid_in;
      end
   end

   // Payload and working registers.
   always_ff @(posedge clock) begin
      requeue_ff   <= requeue_in;
      scan_ff      <= scan_in;
      chk_idx_ff   <= scan_ff[IdW-1:0];
      probe_ff     <= probe_in;
      probe_cnt_ff <= probe_cnt_in;
      status_ff    <= status_in;
      affected_ff  <= affected_in;
      if (accept) begin
         act_ff     <= req_action;
         dur_ff     <= req_duration_ms;
         until_ff   <= req_wake_at_tick;
         tgt_ff     <= req_target_task;
         fromint_ff <= req_from_interrupt;
         before_ff  <= cur_ff;
      end
      if ((state_ff == S_DONE) && rsp_load) begin
         rsp_run_ff    <= cur_wide[PW-1:0];
         rsp_sw_ff     <= (cur_ff != before_ff);
         rsp_status_ff <= status_ff;
         rsp_aff_ff    <= aff_wide[PW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (wk_we) begin
         wake_mem[wk_waddr] <= wk_wdata;
      end
      if (wk_re) begin
         wake_q_ff <= wake_mem[scan_ff[IdW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (ex_we) begin
         ex_mem[ex_tail] <= cur_ff;
      end
      if (ex_re) begin
         ex_q_ff <= ex_mem[ex_head_ff];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_running_task  = rsp_run_ff;
   assign rsp_switched      = rsp_sw_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_affected_task = rsp_aff_ff;

endmodule

FILE: src/rrts_ready_queue.sv
// Ready queue: circular buffer of task ids in a synchronous memory.
module rrts_ready_queue #(
   parameter int MAX_TASKS = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   input  rrts_pkg::rq_cmd_type           cmd,
   input  logic [$clog2(MAX_TASKS)-1:0]   push_id,
   output logic [$clog2(MAX_TASKS+1)-1:0] count,
   output logic [$clog2(MAX_TASKS)-1:0]   rd_data
);

   localparam int IdW  = $clog2(MAX_TASKS);
   localparam int CntW = $clog2(MAX_TASKS + 1);
   localparam int SumW = IdW + 2;

   logic [IdW-1:0]  mem [MAX_TASKS];
   logic [IdW-1:0]  mem_q_ff;
   logic [IdW-1:0]  head_ff, head_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            slot0_written_ff, slot0_written_in;
   logic            rd_zero_ff;
   logic [SumW-1:0] tail_sum;
   logic [IdW-1:0]  tail;
   logic            do_push;

   assign tail_sum = SumW'(head_ff) + SumW'(count_ff);
   assign tail     = (tail_sum >= SumW'(MAX_TASKS)) ? IdW'(tail_sum - SumW'(MAX_TASKS))
                                                    : IdW'(tail_sum);
   // A push onto a full queue is dropped unless a pop frees a slot.
   assign do_push  = cmd.push && ((count_ff != CntW'(MAX_TASKS)) || cmd.pop);

   always_comb begin
      head_in          = head_ff;
      count_in         = count_ff;
      slot0_written_in = slot0_written_ff;
      if (cmd.pop) begin
         head_in = (head_ff == IdW'(MAX_TASKS - 1)) ? '0 : head_ff + IdW'(1);
      end
      if (cmd.pop && !do_push) begin
         count_in = count_ff - CntW'(1);
      end else if (do_push && !cmd.pop) begin
         count_in = count_ff + CntW'(1);
      end
      if (do_push && (tail == '0)) begin
         slot0_written_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff          <= '0;
         count_ff         <= CntW'(1);
         slot0_written_ff <= 1'b0;
      end else begin
         head_ff          <= head_in;
         count_ff         <= count_in;
         slot0_written_ff <= slot0_written_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[tail] <= push_id;
      end
      if (cmd.rd) begin
         mem_q_ff   <= mem[head_ff];
         rd_zero_ff <= (head_ff == '0);
      end
   end

   // Until entry zero is first written it holds the collector id.
   assign rd_data = (rd_zero_ff && !slot0_written_ff) ? IdW'(1) : mem_q_ff;
   assign count   = count_ff;

endmodule

FILE: src/rrts_divider.sv
// Restoring divider, one quotient bit per cycle, for sleep rounding.
module rrts_divider (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [rrts_pkg::DIVIDEND_W-1:0]     dividend,
   input  logic [rrts_pkg::SLOT_W-1:0]         divisor,
   output logic                                done,
   output logic [rrts_pkg::DIVIDEND_W-1:0]     quotient
);

   localparam int DW   = rrts_pkg::DIVIDEND_W;
   localparam int SW   = rrts_pkg::SLOT_W;
   localparam int StpW = $clog2(DW + 1);

   logic [DW-1:0]   quo_ff, quo_in;
   logic [SW-1:0]   rem_ff, rem_in;
   logic [SW-1:0]   div_ff;
   logic [StpW-1:0] step_ff, step_in;
   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [SW:0]     trial;

   assign trial = {rem_ff, quo_ff[DW-1]};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, div_ff}) begin
            rem_in = SW'(trial - {1'b0, div_ff});
            quo_in = {quo_ff[DW-2:0], 1'b1};
         end else begin
            rem_in = SW'(trial);
            quo_in = {quo_ff[DW-2:0], 1'b0};
         end
         step_in = step_ff + StpW'(1);
         if (step_ff == StpW'(DW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      step_ff <= step_in;
      if (start) begin
         div_ff <= divisor;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

FILE: src/rrts_checker.sv
// Port-level checker for the task scheduler, bound to the top level.
module rrts_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [rrts_pkg::PORT_ID_W-1:0] rsp_running_task,
   input logic                           rsp_switched,
   input logic [1:0]                     rsp_status,
   input logic [rrts_pkg::PORT_ID_W-1:0] rsp_affected_task
);

   // A held response word keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_running_task)
                                  && $stable(rsp_status))
      else $error("response word changed while stalled");

   // Events are handled one at a time.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("word accepted while busy");

   // A refused create reports no id.
   a_no_id_on_fail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == rrts_pkg::STATUS_NO_FREE_ID) |-> rsp_affected_task == '0)
      else $error("failed create reported an id");

   // A failed event leaves the running task alone.
   a_no_switch_on_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != rrts_pkg::STATUS_OK) |-> !rsp_switched)
      else $error("failed event switched tasks");

endmodule

bind round_robin_task_scheduler rrts_checker u_rrts_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_running_task  (rsp_running_task),
   .rsp_switched      (rsp_switched),
   .rsp_status        (rsp_status),
   .rsp_affected_task (rsp_affected_task)
);
